/* rtl/emspm_pkg.sv */
// Shared types and constants for the expanded-memory page mapper.
// Used by the top level; no dependencies.
`default_nettype none

package emspm_pkg;

  // function numbers
  localparam logic [7:0] OP_STATUS  = 8'h40;
  localparam logic [7:0] OP_FRAME   = 8'h41;
  localparam logic [7:0] OP_COUNTS  = 8'h42;
  localparam logic [7:0] OP_ALLOC   = 8'h43;
  localparam logic [7:0] OP_MAP     = 8'h44;
  localparam logic [7:0] OP_FREE    = 8'h45;
  localparam logic [7:0] OP_VERSION = 8'h46;

  localparam logic [7:0]  EMS_VERSION = 8'h40;
  localparam logic [15:0] UNMAP_PAGE  = 16'hFFFF;

  // configuration register indexes
  localparam logic [7:0] CFG_ENABLE  = 8'd0;
  localparam logic [7:0] CFG_TOTAL   = 8'd1;
  localparam logic [7:0] CFG_SEGMENT = 8'd2;

  localparam logic        RST_ENABLE  = 1'b1;
  localparam logic [11:0] RST_TOTAL   = 12'd128;
  localparam logic [15:0] RST_SEGMENT = 16'hE000;

  localparam logic [11:0] CNT_MAX = 12'hFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNSUP     = 3'd1,
    ST_NOHANDLE  = 3'd2,
    ST_FEW       = 3'd3,
    ST_ZERO      = 3'd4,
    ST_BADLOG    = 3'd5,
    ST_BADSLOT   = 3'd6,
    ST_BADHANDLE = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  operation;
    logic [15:0] arg_bx;
    logic [15:0] arg_dx;
    logic [7:0]  arg_al;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] bx_out;
    logic [15:0] dx_out;
    logic [7:0]  al_out;
    logic [1:0]  frame_slot;
    logic        save_valid;
    logic [10:0] save_page;
    logic        load_valid;
    logic [10:0] load_page;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/emspm_cnt_ram.sv */
// Page-count store per handle: one write port, one registered read port.
// No dependencies.
`default_nettype none

module emspm_cnt_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/expanded_memory_page_mapper.sv */
// Expanded-memory page mapper top level: request sequencer, handle table, slots.
// Depends on emspm_pkg and emspm_cnt_ram.
//
//  channel | signals                                      | direction
//  in_     | in_valid, in_stall, in_data                  | request transaction in
//  out_    | out_valid, out_stall, out_data               | result transaction out
//  cfg_    | cfg_valid, cfg_ready, cfg_index, cfg_data    | register write in
//
// One request at a time; in_stall is low only while the sequencer is idle.
// Simple functions go from decode straight to the result. Allocate tests handle flags from
// handle 1 upward (one handle flag tested per cycle). Map walks the page counts of the
// handles below dx through the count RAM (one read per cycle). Free returns the pages and,
// if any slot is mapped, scans the slots and gives one result per mapped slot.
// Synchronous active-low reset; no clearing pass. A stalled result holds the sequencer.
`default_nettype none

module expanded_memory_page_mapper #(
  parameter int HANDLE_COUNT = 16,
  parameter int FRAME_SLOTS  = 4,
  parameter int MAX_PAGES    = 2048
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire emspm_pkg::req_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output emspm_pkg::res_t       out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);

  localparam int IDX_W  = $clog2(HANDLE_COUNT);
  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int SUM_W  = IDX_W + 17;
  localparam logic [15:0]      HC16     = 16'(HANDLE_COUNT);
  localparam logic [7:0]       FS8      = 8'(FRAME_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HANDLE_COUNT - 1);
  localparam logic [SUM_W-1:0] MAXPG    = SUM_W'(MAX_PAGES);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DECODE    = 9'b000000010,
    S_ALLOC     = 9'b000000100,
    S_MAP_LOG   = 9'b000001000,
    S_SUM       = 9'b000010000,
    S_MAP_CHK   = 9'b000100000,
    S_FREE_ADD  = 9'b001000000,
    S_FREE_SCAN = 9'b010000000,
    S_OUT       = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  emspm_pkg::req_t req_r;
  emspm_pkg::res_t out_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic more_r, more_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic pend_r, pend_nxt;
  logic [11:0] free_r, free_nxt;
  logic [HANDLE_COUNT-1:0] in_use_r, in_use_nxt;
  logic [FRAME_SLOTS-1:0] slot_map_r, slot_map_nxt;
  logic [11:0] slot_pg_r [FRAME_SLOTS];
  logic slot_pg_we;
  logic [11:0] slot_pg_wdata;
  logic [SLOT_W-1:0] sp_r, sp_nxt;
  logic en_r;
  logic [11:0] tot_r;
  logic [15:0] seg_r;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [11:0] ram_wdata, cnt_rd;

  logic [IDX_W-1:0] hidx;
  logic [SLOT_W-1:0] aidx;
  logic handle_ok, slot_ok;
  logic [SUM_W-1:0] pg;
  logic [12:0] free_sum;
  logic [11:0] cur_pg;
  logic cur_map;
  logic [FRAME_SLOTS-1:0] sp_bit;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign hidx      = req_r.arg_dx[IDX_W-1:0];
  assign aidx      = req_r.arg_al[SLOT_W-1:0];
  assign handle_ok = (req_r.arg_dx != 16'd0) && (req_r.arg_dx < HC16) && in_use_r[hidx];
  assign slot_ok   = (req_r.arg_al < FS8);
  assign pg        = acc_r + SUM_W'(req_r.arg_bx);
  assign free_sum  = {1'b0, free_r} + {1'b0, cnt_rd};
  assign ram_raddr = (state_r == S_SUM) ? idx_r : hidx;
  // one read mux on the slot pages: map uses arg_al, free walks sp_r
  assign cur_pg    = (state_r == S_FREE_SCAN) ? slot_pg_r[sp_r] : slot_pg_r[aidx];
  assign cur_map   = slot_map_r[aidx];
  assign sp_bit    = FRAME_SLOTS'(1) << sp_r;

  emspm_cnt_ram #(
    .DEPTH (HANDLE_COUNT),
    .AW    (IDX_W),
    .DW    (12)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (cnt_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    more_nxt      = more_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    free_nxt      = free_r;
    in_use_nxt    = in_use_r;
    slot_map_nxt  = slot_map_r;
    slot_pg_we    = 1'b0;
    slot_pg_wdata = pg[11:0];
    sp_nxt        = sp_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = req_r.arg_bx[11:0];
    res_nxt       = '0;
    res_nxt.last  = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        more_nxt  = 1'b0;
        if (!en_r) begin
          res_nxt.status = emspm_pkg::ST_UNSUP;
        end else begin
          case (req_r.operation)
            emspm_pkg::OP_STATUS: ;
            emspm_pkg::OP_FRAME:   res_nxt.bx_out = seg_r;
            emspm_pkg::OP_COUNTS: begin
              res_nxt.bx_out = 16'(free_r);
              res_nxt.dx_out = 16'(tot_r);
            end
            emspm_pkg::OP_VERSION: res_nxt.al_out = emspm_pkg::EMS_VERSION;
            emspm_pkg::OP_ALLOC: begin
              if (req_r.arg_bx == 16'd0) begin
                res_nxt.status = emspm_pkg::ST_ZERO;
              end else if (req_r.arg_bx > 16'(free_r)) begin
                res_nxt.status = emspm_pkg::ST_FEW;
              end else begin
                idx_nxt   = IDX_W'(1);
                state_nxt = S_ALLOC;
              end
            end
            emspm_pkg::OP_MAP: begin
              if (!slot_ok) begin
                res_nxt.status = emspm_pkg::ST_BADSLOT;
              end else if (!handle_ok) begin
                res_nxt.status = emspm_pkg::ST_BADHANDLE;
              end else if (req_r.arg_bx == emspm_pkg::UNMAP_PAGE) begin
                res_nxt.frame_slot = 2'(aidx);
                res_nxt.save_valid = cur_map;
                res_nxt.save_page  = cur_map ? cur_pg[10:0] : 11'd0;
                slot_map_nxt[aidx] = 1'b0;
              end else begin
                state_nxt = S_MAP_LOG;   // count of dx is read this cycle
              end
            end
            emspm_pkg::OP_FREE: begin
              if (!handle_ok) begin
                res_nxt.status = emspm_pkg::ST_BADHANDLE;
              end else begin
                state_nxt = S_FREE_ADD;
              end
            end
            default: res_nxt.status = emspm_pkg::ST_UNSUP;
          endcase
        end
      end
      S_ALLOC: begin
        if (!in_use_r[idx_r]) begin
          ram_we            = 1'b1;
          in_use_nxt[idx_r] = 1'b1;
          free_nxt          = free_r - req_r.arg_bx[11:0];
          res_nxt.dx_out    = 16'(idx_r);
          more_nxt          = 1'b0;
          state_nxt         = S_OUT;
        end else if (idx_r == IDX_LAST) begin
          res_nxt.status = emspm_pkg::ST_NOHANDLE;
          more_nxt       = 1'b0;
          state_nxt      = S_OUT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_MAP_LOG: begin
        if (req_r.arg_bx[15] || (req_r.arg_bx >= 16'(cnt_rd))) begin
          res_nxt.status = emspm_pkg::ST_BADLOG;
          more_nxt       = 1'b0;
          state_nxt      = S_OUT;
        end else begin
          idx_nxt   = IDX_W'(1);
          acc_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        // read issued for idx_r, summed in the next cycle under pend_r
        if (pend_r) begin
          acc_nxt = acc_r + SUM_W'(cnt_rd);
        end
        if (idx_r != hidx) begin
          pend_nxt = in_use_r[idx_r];
          idx_nxt  = idx_r + IDX_W'(1);
        end else begin
          state_nxt = S_MAP_CHK;
        end
      end
      S_MAP_CHK: begin
        more_nxt  = 1'b0;
        state_nxt = S_OUT;
        if ((pg >= SUM_W'(tot_r)) || (pg >= MAXPG)) begin
          res_nxt.status = emspm_pkg::ST_BADLOG;
        end else begin
          res_nxt.frame_slot = 2'(aidx);
          if (!(cur_map && (cur_pg == pg[11:0]))) begin
            res_nxt.save_valid = cur_map;
            res_nxt.save_page  = cur_map ? cur_pg[10:0] : 11'd0;
            res_nxt.load_valid = 1'b1;
            res_nxt.load_page  = pg[10:0];
            slot_map_nxt[aidx] = 1'b1;
            slot_pg_we         = 1'b1;
          end
        end
      end
      S_FREE_ADD: begin
        free_nxt         = free_sum[12] ? emspm_pkg::CNT_MAX : free_sum[11:0];
        in_use_nxt[hidx] = 1'b0;
        if (slot_map_r == '0) begin
          more_nxt  = 1'b0;
          state_nxt = S_OUT;
        end else begin
          sp_nxt    = '0;
          state_nxt = S_FREE_SCAN;
        end
      end
      S_FREE_SCAN: begin
        sp_nxt = sp_r + SLOT_W'(1);
        if (slot_map_r[sp_r]) begin
          res_nxt.frame_slot = 2'(sp_r);
          res_nxt.save_valid = 1'b1;
          res_nxt.save_page  = cur_pg[10:0];
          res_nxt.last       = ((slot_map_r & ~sp_bit) == '0);
          slot_map_nxt[sp_r] = 1'b0;
          more_nxt           = !res_nxt.last;
          state_nxt          = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = more_r ? S_FREE_SCAN : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (state_nxt == S_OUT && state_r != S_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (state_r == S_OUT && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      more_r      <= 1'b0;
      pend_r      <= 1'b0;
      free_r      <= emspm_pkg::RST_TOTAL;
      in_use_r    <= '0;
      slot_map_r  <= '0;
      en_r        <= emspm_pkg::RST_ENABLE;
      tot_r       <= emspm_pkg::RST_TOTAL;
      seg_r       <= emspm_pkg::RST_SEGMENT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      more_r      <= more_nxt;
      pend_r      <= pend_nxt;
      free_r      <= free_nxt;
      in_use_r    <= in_use_nxt;
      slot_map_r  <= slot_map_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          emspm_pkg::CFG_ENABLE:  en_r  <= cfg_data[0];
          emspm_pkg::CFG_TOTAL:   tot_r <= cfg_data[11:0];
          emspm_pkg::CFG_SEGMENT: seg_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    sp_r  <= sp_nxt;
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_data;
    end
    if (state_nxt == S_OUT && state_r != S_OUT) begin
      out_r <= res_nxt;
    end
    if (slot_pg_we) begin
      slot_pg_r[aidx] <= slot_pg_wdata;
    end
  end

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid_r)
    else $error("request accepted while a result is pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && out_r.last |=> !in_stall)
    else $error("sequencer not idle after final result");

  a_more_is_free_save: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> out_r.save_valid && !out_r.load_valid &&
      (out_r.status == emspm_pkg::ST_OK))
    else $error("non-final result that is not a free save");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.save_valid || out_r.load_valid) |->
      (32'(out_r.frame_slot) < FRAME_SLOTS))
    else $error("copy command for a slot that does not exist");

  a_free_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FREE_SCAN |-> slot_map_r != '0)
    else $error("free slot walk with nothing mapped");

endmodule

`default_nettype wire
